// ===== rtl/skt_pkg.sv =====
// Shared constants and codes for the sorted key table.
package skt_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int OUT_CNT_W = 5;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

endpackage

// ===== rtl/skt_req_if.sv =====
// Request channel: valid/ready plus request type and key.
interface skt_req_if import skt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

// ===== rtl/skt_rsp_if.sv =====
// Response channel: valid/ready plus status, matched key and entry count.
interface skt_rsp_if import skt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [KEY_W-1:0] matched_key;
  logic [OUT_CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output matched_key, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input matched_key, input entry_count,
                  output ready);
endinterface

// ===== rtl/sorted_key_table_top.sv =====
// Top level of the sorted key table: request sequencer around one key RAM.
//
// Usage
//   in_req  : request beats {req_type, key}; insert, find or delete one key.
//   out_rsp : one response beat per request {status, matched_key, entry_count}.
//   cfg_we / cfg_wdata : write the capacity register (reset 16) only while idle.
// Operation
//   Keys sit in ascending order in a DEPTH-entry RAM with registered read
//   data. Each request walks the table from entry 0, one entry per cycle,
//   reading entry i+1 while writing back entry i (insert ripples keys up,
//   delete ripples them down), so no access ever overlaps an unfinished write.
// Sequencing
//   One request at a time: accept, a walk up to the stop position (up to the
//   stored count for insert and delete, up to the first key not below the
//   request key for find), then hand-off. Full inserts and unused request
//   types skip the walk.
// Reset and stalls
//   Reset empties the table (count zero, RAM contents left as they are) and
//   drops any pending response. A stalled receiver holds the response beat;
//   the next request is accepted meanwhile and waits only at hand-off.
module sorted_key_table_top import skt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  skt_req_if.sink              in_req,
  skt_rsp_if.source            out_rsp,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                  state_r, state_nxt;
  logic [1:0]              op_r, op_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;      // entry whose read data is on ram_rdata
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CAP_W-1:0]        cap_r, cap_nxt;
  logic                    flag_r, flag_nxt;    // insert: key placed; delete: key found
  logic [KEY_W-1:0]        carry_r, carry_nxt;  // key displaced by an insert
  logic [1:0]              res_status_r, res_status_nxt;
  logic [KEY_W-1:0]        res_match_r, res_match_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic [KEY_W-1:0]        out_match_r, out_match_nxt;
  logic [OUT_CNT_W-1:0]    out_count_r, out_count_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [KEY_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [KEY_W-1:0]        ram_rdata;

  logic                    accept;
  logic [LIM_W-1:0]        cap_ext;
  logic [LIM_W-1:0]        lim;
  logic                    full;
  logic                    at_end;
  logic                    key_lt;
  logic                    key_eq;

  skt_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready        = (state_r == S_IDLE);
  assign accept              = in_req.valid && in_req.ready;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.matched_key = out_match_r;
  assign out_rsp.entry_count = out_count_r;

  // Capacity saturates at the table depth.
  assign cap_ext = LIM_W'(cap_r);
  assign lim     = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
  assign full    = (LIM_W'(count_r) >= lim);

  assign at_end  = (ptr_r == count_r);
  assign key_lt  = ($signed(ram_rdata) < $signed(key_r));
  assign key_eq  = (ram_rdata == key_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    cap_nxt        = cfg_we ? cfg_wdata : cap_r;
    flag_nxt       = flag_r;
    carry_nxt      = carry_r;
    res_status_nxt = res_status_r;
    res_match_nxt  = res_match_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_match_nxt  = out_match_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r[IDX_W-1:0];
    ram_wdata      = key_r;
    ram_raddr      = IDX_W'(ptr_r + 1'b1);

    case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (accept) begin
          op_nxt         = in_req.req_type;
          key_nxt        = in_req.key;
          ptr_nxt        = '0;
          flag_nxt       = 1'b0;
          res_match_nxt  = '0;
          if (in_req.req_type == OP_INSERT && full) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else if (in_req.req_type != OP_INSERT && in_req.req_type != OP_FIND &&
                       in_req.req_type != OP_DELETE) begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end

      S_RUN: begin
        ptr_nxt = ptr_r + 1'b1;
        case (op_r)
          OP_INSERT: begin
            // Drop the new key at the first slot not below it, then ripple up.
            ram_we    = 1'b1;
            carry_nxt = ram_rdata;
            if (!flag_r && (at_end || !key_lt)) begin
              ram_wdata = key_r;
              flag_nxt  = 1'b1;
            end else if (flag_r) begin
              ram_wdata = carry_r;
            end else begin
              ram_we = 1'b0;
            end
            if (at_end) begin
              count_nxt      = count_r + 1'b1;
              res_status_nxt = ST_OK;
              state_nxt      = S_DONE;
            end
          end
          OP_FIND: begin
            if (at_end || !key_lt) begin
              if (!at_end && key_eq) begin
                res_status_nxt = ST_OK;
                res_match_nxt  = ram_rdata;
              end else begin
                res_status_nxt = ST_MISS;
              end
              state_nxt = S_DONE;
            end
          end
          OP_DELETE: begin
            if (!flag_r) begin
              if (at_end || !key_lt) begin
                if (!at_end && key_eq) begin
                  flag_nxt = 1'b1;
                end else begin
                  res_status_nxt = ST_MISS;
                  state_nxt      = S_DONE;
                end
              end
            end else if (at_end) begin
              count_nxt      = count_r - 1'b1;
              res_status_nxt = ST_OK;
              state_nxt      = S_DONE;
            end else begin
              // Close the gap: move this entry down by one.
              ram_we    = 1'b1;
              ram_waddr = IDX_W'(ptr_r - 1'b1);
              ram_wdata = ram_rdata;
            end
          end
          default: begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        ram_raddr = '0;
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_match_nxt  = res_match_r;
          out_count_nxt  = OUT_CNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_W'(16);
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      flag_r      <= flag_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    ptr_r        <= ptr_nxt;
    carry_r      <= carry_nxt;
    res_status_r <= res_status_nxt;
    res_match_r  <= res_match_nxt;
    out_status_r <= out_status_nxt;
    out_match_r  <= out_match_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// ===== rtl/skt_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/skt_chk.sv =====
// Port-level checker for the sorted key table, bound to the top level.
module skt_chk import skt_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [KEY_W-1:0]     out_matched_key,
  input logic [OUT_CNT_W-1:0] out_entry_count
);

  // Hold a stalled response beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_matched_key))
    else $error("response beat dropped or changed under stall");

  // One request at a time: ready drops right after an accepted beat.
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in flight");

  // A matched key appears only with a successful status.
  a_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_matched_key == '0)
    else $error("matched key nonzero on a failed request");

  // The count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= DEPTH)
    else $error("entry count above table depth");

endmodule

bind sorted_key_table_top skt_chk u_skt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_matched_key (out_rsp.matched_key),
  .out_entry_count (out_rsp.entry_count)
);

// ===== tb/sv/tb_sorted_key_table_top.sv =====
// Self-checking testbench for sorted_key_table_top: directed rows, then randomized phases.
`timescale 1ns / 100ps

module tb_sorted_key_table_top;
  import skt_pkg::*;

  // Request type the block answers with a miss and otherwise ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] MIN_KEY = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] MAX_KEY = {1'b0, {(KEY_W-1){1'b1}}};

  localparam int IDLE_PCT        = 35;
  localparam int SETTLE_CYCLES   = DEPTH + 4;
  localparam int DRAIN_CYCLES    = DEPTH + 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT     = 60;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int STEADY_PHASE    = 3;
  localparam int SWING_LEN       = 64;

  // Capacity per random phase: nominal, saturating, tiny, zero (below the count).
  localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
    5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd8, 5'd17, 5'd3, 5'd16
  };

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] matched_key;
    logic [OUT_CNT_W-1:0]    entry_count;
  } rsp_beat_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CAP_W-1:0]        cap;
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
    logic                    fixed;
    rsp_beat_t               want;
  } table_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  skt_req_if req_ch ();
  skt_rsp_if rsp_ch ();

  sorted_key_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the table, its count and the capacity register.
  logic signed [KEY_W-1:0] model_keys [DEPTH];
  int                      model_count;
  logic [CAP_W-1:0]        model_cap;

  // Responses still owed by the block, oldest first.
  rsp_beat_t pending_rsp [$];

  int  mismatch_count;
  int  stall_cycles;
  int  n_insert, n_find, n_delete, n_unused, n_full, n_hit, cap_writes;
  bit  steady_flow;
  bit  hold_off_req;

  // Directed rows. Typed-in responses cover the plain cases; rows with
  // fixed = 0 are checked against the shadow table only.
  table_row_t directed_rows [27] = '{
    // empty table after reset: misses and the ignored request type
    '{ROW_REQ, 5'd0, OP_FIND,   32'sd0,       1'b1, '{ST_MISS, 32'sd0, 5'd0}},
    '{ROW_REQ, 5'd0, OP_DELETE, 32'sd5,       1'b1, '{ST_MISS, 32'sd0, 5'd0}},
    '{ROW_REQ, 5'd0, OP_UNUSED, -32'sd1,      1'b1, '{ST_MISS, 32'sd0, 5'd0}},
    // extremes of the key, then a duplicate
    '{ROW_REQ, 5'd0, OP_INSERT, MAX_KEY,      1'b1, '{ST_OK,   32'sd0, 5'd1}},
    '{ROW_REQ, 5'd0, OP_INSERT, MIN_KEY,      1'b1, '{ST_OK,   32'sd0, 5'd2}},
    '{ROW_REQ, 5'd0, OP_INSERT, 32'sd0,       1'b1, '{ST_OK,   32'sd0, 5'd3}},
    '{ROW_REQ, 5'd0, OP_INSERT, 32'sd0,       1'b1, '{ST_OK,   32'sd0, 5'd4}},
    '{ROW_REQ, 5'd0, OP_INSERT, -32'sd1,      1'b0, '{ST_OK,   32'sd0, 5'd0}},
    '{ROW_REQ, 5'd0, OP_FIND,   MIN_KEY,      1'b1, '{ST_OK,   MIN_KEY, 5'd5}},
    '{ROW_REQ, 5'd0, OP_FIND,   MAX_KEY,      1'b1, '{ST_OK,   MAX_KEY, 5'd5}},
    '{ROW_REQ, 5'd0, OP_FIND,   32'sd1,       1'b1, '{ST_MISS, 32'sd0, 5'd5}},
    '{ROW_REQ, 5'd0, OP_DELETE, 32'sd0,       1'b1, '{ST_OK,   32'sd0, 5'd4}},
    '{ROW_REQ, 5'd0, OP_FIND,   32'sd0,       1'b0, '{ST_OK,   32'sd0, 5'd0}},
    '{ROW_REQ, 5'd0, OP_DELETE, 32'sd0,       1'b1, '{ST_OK,   32'sd0, 5'd3}},
    '{ROW_REQ, 5'd0, OP_DELETE, 32'sd0,       1'b1, '{ST_MISS, 32'sd0, 5'd3}},
    '{ROW_REQ, 5'd0, OP_UNUSED, 32'h55555555, 1'b1, '{ST_MISS, 32'sd0, 5'd3}},
    '{ROW_REQ, 5'd0, OP_DELETE, MIN_KEY,      1'b1, '{ST_OK,   32'sd0, 5'd2}},
    '{ROW_REQ, 5'd0, OP_DELETE, MAX_KEY,      1'b1, '{ST_OK,   32'sd0, 5'd1}},
    // capacity zero while one key is held: refuse until emptied, and after
    '{ROW_CFG, 5'd0, OP_FIND,   32'sd0,       1'b0, '{ST_OK,   32'sd0, 5'd0}},
    '{ROW_REQ, 5'd0, OP_INSERT, 32'sd7,       1'b1, '{ST_FULL, 32'sd0, 5'd1}},
    '{ROW_REQ, 5'd0, OP_DELETE, -32'sd1,      1'b1, '{ST_OK,   32'sd0, 5'd0}},
    '{ROW_REQ, 5'd0, OP_INSERT, 32'sd3,       1'b1, '{ST_FULL, 32'sd0, 5'd0}},
    // capacity two: fill up, then the third insert bounces
    '{ROW_CFG, 5'd2, OP_FIND,   32'sd0,       1'b0, '{ST_OK,   32'sd0, 5'd0}},
    '{ROW_REQ, 5'd0, OP_INSERT, 32'sd10,      1'b1, '{ST_OK,   32'sd0, 5'd1}},
    '{ROW_REQ, 5'd0, OP_INSERT, 32'sd20,      1'b1, '{ST_OK,   32'sd0, 5'd2}},
    '{ROW_REQ, 5'd0, OP_INSERT, 32'sd15,      1'b1, '{ST_FULL, 32'sd0, 5'd2}},
    '{ROW_REQ, 5'd0, OP_FIND,   32'sd20,      1'b0, '{ST_OK,   32'sd0, 5'd0}}
  };

  // Apply one request to the shadow table and return the response it owes.
  function automatic rsp_beat_t table_update(input logic [1:0] op,
                                             input logic signed [KEY_W-1:0] k);
    rsp_beat_t r;
    int lim;
    int pos;
    int i;
    r.status      = ST_MISS;
    r.matched_key = '0;
    // capacity saturates at the table depth
    lim = (int'(model_cap) > DEPTH) ? DEPTH : int'(model_cap);
    // first stored key that is not below k
    pos = 0;
    while (pos < model_count && model_keys[pos] < k) pos++;
    case (op)
      OP_INSERT: begin
        if (model_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          for (i = model_count; i > pos; i--) model_keys[i] = model_keys[i - 1];
          model_keys[pos] = k;
          model_count++;
          r.status = ST_OK;
        end
      end
      OP_FIND: begin
        if (pos < model_count && model_keys[pos] == k) begin
          r.status      = ST_OK;
          r.matched_key = k;
        end
      end
      OP_DELETE: begin
        if (pos < model_count && model_keys[pos] == k) begin
          for (i = pos; i < model_count - 1; i++) model_keys[i] = model_keys[i + 1];
          model_count--;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.entry_count = OUT_CNT_W'(model_count);
    return r;
  endfunction

  // Offer one request beat, hold it until accepted, then queue its response.
  task automatic push_request(input logic [1:0] op, input logic signed [KEY_W-1:0] k,
                              input logic use_fixed, input rsp_beat_t fixed_beat);
    rsp_beat_t want;
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    do @(posedge clk); while (!req_ch.ready);
    want = table_update(op, k);
    case (op)
      OP_INSERT: n_insert++;
      OP_FIND:   n_find++;
      OP_DELETE: n_delete++;
      default:   n_unused++;
    endcase
    if (want.status == ST_FULL) n_full++;
    if (op == OP_FIND && want.status == ST_OK) n_hit++;
    pending_rsp.push_back(use_fixed ? fixed_beat : want);
  endtask

  // Write the capacity register once the block has gone quiet.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_cap = value;
    cap_writes++;
  endtask

  // 250 MHz clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Response side: drop ready at random, except in the steady phase, and
  // honor one long hold-off so the block backs up into its input.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every response beat with the oldest queued expectation.
  always @(posedge clk) begin : rsp_check
    rsp_beat_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response beat: status %0d, matched_key %0d, entry_count %0d",
               rsp_ch.status, rsp_ch.matched_key, rsp_ch.entry_count);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.matched_key !== want.matched_key) begin
          $error("matched_key: expected %0d, got %0d", want.matched_key, rsp_ch.matched_key);
          mismatch_count++;
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_ch.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence.
  initial begin
    int                      phase;
    int                      n;
    int                      roll;
    bit                      filling;
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;

    mismatch_count = 0;
    n_insert = 0; n_find = 0; n_delete = 0; n_unused = 0;
    n_full = 0; n_hit = 0; cap_writes = 0;
    steady_flow  = 1'b0;
    hold_off_req = 1'b0;
    model_count  = 0;
    model_cap    = 5'd16;

    // Hold every input at a known value through reset.
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= OP_FIND;
    req_ch.key      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed rows.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_capacity(directed_rows[i].cap);
      end else begin
        push_request(directed_rows[i].op, directed_rows[i].key,
                     directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    // Random phases, one capacity each. Swing between fill-heavy and
    // drain-heavy stretches so the table runs full and empty repeatedly;
    // aim most finds and deletes at keys that are actually stored.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_capacity(PHASE_CAPS[phase]);
      steady_flow = (phase == STEADY_PHASE);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == HOLD_OFF_AT) hold_off_req = 1'b1;
        filling = ((n / SWING_LEN) % 2) == 0;
        roll = $urandom_range(99);
        if (roll < (filling ? 50 : 20)) op = OP_INSERT;
        else if (roll < (filling ? 75 : 40)) op = OP_FIND;
        else if (roll < 95) op = OP_DELETE;
        else op = OP_UNUSED;

        roll = $urandom_range(99);
        if (op != OP_INSERT && model_count > 0 && roll < 55) begin
          key = model_keys[$urandom_range(model_count - 1, 0)];
        end else if (roll < 75) begin
          // small keys collide often: duplicates and near misses
          key = KEY_W'($urandom_range(16)) - KEY_W'(8);
        end else if (roll < 85) begin
          key = $urandom_range(1) ? MAX_KEY - $urandom_range(1) : MIN_KEY + $urandom_range(1);
        end else begin
          key = $urandom;
        end
        push_request(op, key, 1'b0, '0);
      end
    end
    steady_flow = 1'b0;

    // Drain: wait for every owed response, then let the block settle.
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d insert, %0d find, %0d delete, %0d unused type.",
             n_insert + n_find + n_delete + n_unused, n_insert, n_find, n_delete, n_unused);
    $display("%0d inserts refused on a full table, %0d finds matched, %0d capacity writes.",
             n_full, n_hit, cap_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
